### src/assert_macros.svh
// Assertion macros shared by the record parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ARHP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property must never hold at a clock edge outside reset.
`define ARHP_ASSERT_NEVER(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) not (prop)) else $error(msg);
`else
`define ARHP_ASSERT(lbl, clk, rst, prop, msg)
`define ARHP_ASSERT_NEVER(lbl, clk, rst, prop, msg)
`endif
`endif

### src/arhp_pkg.sv
// Types and constants of the hex record parser.
package arhp_pkg;

   typedef struct packed {
      logic [7:0] hex_char;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        run_last;
      logic [7:0]  user_byte;
      logic [1:0]  status;
      logic [47:0] first_mac;
      logic [31:0] mode_word;
      logic [31:0] time_left;
      logic [7:0]  user_count;
   } rsp_type;

   // Up to two results caused by one transfer; a lone result sits in first.
   typedef struct packed {
      logic    first_valid;
      logic    second_valid;
      rsp_type first;
      rsp_type second;
   } res_pair_type;

   localparam logic KIND_USER    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_SHORT     = 2'd1;
   localparam logic [1:0] ST_VERSION   = 2'd2;
   localparam logic [1:0] ST_MAC_COUNT = 2'd3;

   localparam logic CSR_VERSION = 1'b0;
   localparam logic CSR_KEY     = 1'b1;

   localparam logic [7:0] VERSION_RESET = 8'd1;
   localparam logic [7:0] KEY_RESET     = 8'hDA;

   // Header byte positions.
   localparam logic [4:0] POS_VERSION = 5'd0;
   localparam logic [4:0] POS_COUNT   = 5'd1;
   localparam logic [4:0] MAC_END     = 5'd8;
   localparam logic [4:0] BASE_ONE    = 5'd8;
   localparam logic [4:0] BASE_TWO    = 5'd14;
   localparam logic [4:0] POS_MAX     = 5'd23;

   localparam int QDEPTH = 3;

endpackage

### src/arhp_parser.sv
// Character decoder and record field state; produces the results of one transfer.
`include "assert_macros.svh"
module arhp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  arhp_pkg::req_type     req,
   input  logic [7:0]            expected_version,
   input  logic [7:0]            xor_key,
   output arhp_pkg::res_pair_type res
);
   import arhp_pkg::*;

   logic [3:0]  high_ff, high_in, high_upd;
   logic        pending_ff, pending_in, pending_upd;
   logic        stopped_ff, stopped_in, stopped_upd;
   logic [4:0]  pos_ff, pos_in, pos_upd;
   logic        two_ff, two_in, two_upd;
   logic [1:0]  err_ff, err_in, err_upd;
   logic [47:0] mac_ff, mac_in, mac_upd;
   logic [31:0] mode_ff, mode_in, mode_upd;
   logic [31:0] time_ff, time_in, time_upd;
   logic [7:0]  len_ff, len_in, len_upd;
   logic [7:0]  emit_ff, emit_in, emit_upd;

   logic        is_digit, is_lower, is_upper, is_alnum;
   logic [7:0]  nib_wide;
   logic [7:0]  dec_byte;
   logic [4:0]  base, base_upd;
   logic        byte_out;
   logic [1:0]  st;
   rsp_type     user_rsp, sum_rsp;
   logic        clear;

   always_comb begin
      is_digit = (req.hex_char >= 8'h30) && (req.hex_char <= 8'h39);
      is_lower = (req.hex_char >= 8'h61) && (req.hex_char <= 8'h7A);
      is_upper = (req.hex_char >= 8'h41) && (req.hex_char <= 8'h5A);
      is_alnum = is_digit || is_lower || is_upper;
      if (is_digit) begin
         nib_wide = req.hex_char - 8'h30;
      end else if (is_lower) begin
         nib_wide = req.hex_char - 8'h57;
      end else begin
         nib_wide = req.hex_char - 8'h37;
      end
      dec_byte = {high_ff, nib_wide[3:0]} ^ xor_key;
      base     = two_ff ? BASE_TWO : BASE_ONE;
   end

   always_comb begin
      high_upd    = high_ff;
      pending_upd = pending_ff;
      stopped_upd = stopped_ff;
      pos_upd     = pos_ff;
      two_upd     = two_ff;
      err_upd     = err_ff;
      mac_upd     = mac_ff;
      mode_upd    = mode_ff;
      time_upd    = time_ff;
      len_upd     = len_ff;
      emit_upd    = emit_ff;
      byte_out    = 1'b0;
      if (accept && !stopped_ff) begin
         if (!is_alnum) begin
            stopped_upd = 1'b1;
            pending_upd = 1'b0;
         end else if (!pending_ff) begin
            high_upd    = nib_wide[3:0];
            pending_upd = 1'b1;
         end else begin
            pending_upd = 1'b0;
            if (err_ff == ST_OK) begin
               if (pos_ff == POS_VERSION) begin
                  if (dec_byte != expected_version) begin
                     err_upd = ST_VERSION;
                  end else begin
                     pos_upd = pos_ff + 5'd1;
                  end
               end else if (pos_ff == POS_COUNT) begin
                  if (dec_byte != 8'd1 && dec_byte != 8'd2) begin
                     err_upd = ST_MAC_COUNT;
                  end else begin
                     two_upd = (dec_byte == 8'd2);
                     pos_upd = pos_ff + 5'd1;
                  end
               end else if (pos_ff < MAC_END) begin
                  mac_upd = {mac_ff[39:0], dec_byte};
                  pos_upd = pos_ff + 5'd1;
               end else if (pos_ff < base) begin
                  pos_upd = pos_ff + 5'd1;
               end else if (pos_ff < base + 5'd4) begin
                  mode_upd = {mode_ff[23:0], dec_byte};
                  pos_upd  = pos_ff + 5'd1;
               end else if (pos_ff < base + 5'd8) begin
                  time_upd = {time_ff[23:0], dec_byte};
                  pos_upd  = pos_ff + 5'd1;
               end else if (pos_ff == base + 5'd8) begin
                  len_upd = dec_byte;
                  pos_upd = pos_ff + 5'd1;
               end else if (emit_ff < len_ff) begin
                  emit_upd = emit_ff + 8'd1;
                  byte_out = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      base_upd = two_upd ? BASE_TWO : BASE_ONE;
      st       = err_upd;
      if (st == ST_OK && pos_upd < base_upd + 5'd9) begin
         st = ST_SHORT;
      end

      user_rsp           = '0;
      user_rsp.kind      = KIND_USER;
      user_rsp.run_last  = !req.is_last;
      user_rsp.user_byte = dec_byte;

      sum_rsp            = '0;
      sum_rsp.kind       = KIND_SUMMARY;
      sum_rsp.run_last   = 1'b1;
      sum_rsp.status     = st;
      sum_rsp.first_mac  = (pos_upd >= MAC_END) ? mac_upd : '0;
      sum_rsp.mode_word  = (pos_upd >= base_upd + 5'd4) ? mode_upd : '0;
      sum_rsp.time_left  = (pos_upd >= base_upd + 5'd8) ? time_upd : '0;
      sum_rsp.user_count = emit_upd;

      clear = accept && req.is_last;

      res.first_valid  = byte_out || clear;
      res.second_valid = byte_out && clear;
      res.first        = byte_out ? user_rsp : sum_rsp;
      res.second       = sum_rsp;
   end

   // Drop all record state after the summary so the next character starts fresh.
   always_comb begin
      high_in    = clear ? '0 : high_upd;
      pending_in = clear ? 1'b0 : pending_upd;
      stopped_in = clear ? 1'b0 : stopped_upd;
      pos_in     = clear ? '0 : pos_upd;
      two_in     = clear ? 1'b0 : two_upd;
      err_in     = clear ? ST_OK : err_upd;
      mac_in     = clear ? '0 : mac_upd;
      mode_in    = clear ? '0 : mode_upd;
      time_in    = clear ? '0 : time_upd;
      len_in     = clear ? '0 : len_upd;
      emit_in    = clear ? '0 : emit_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff    <= '0;
         pending_ff <= 1'b0;
         stopped_ff <= 1'b0;
         pos_ff     <= '0;
         two_ff     <= 1'b0;
         err_ff     <= ST_OK;
         mac_ff     <= '0;
         mode_ff    <= '0;
         time_ff    <= '0;
         len_ff     <= '0;
         emit_ff    <= '0;
      end else begin
         high_ff    <= high_in;
         pending_ff <= pending_in;
         stopped_ff <= stopped_in;
         pos_ff     <= pos_in;
         two_ff     <= two_in;
         err_ff     <= err_in;
         mac_ff     <= mac_in;
         mode_ff    <= mode_in;
         time_ff    <= time_in;
         len_ff     <= len_in;
         emit_ff    <= emit_in;
      end
   end

   `ARHP_ASSERT(a_pos_bound, clock, reset, pos_ff <= POS_MAX, "header position out of range")
   `ARHP_ASSERT(a_clear_after_last, clock, reset,
      (accept && req.is_last) |=> (pos_ff == POS_VERSION && !pending_ff && !stopped_ff),
      "state not cleared after summary")
   `ARHP_ASSERT(a_err_sticky, clock, reset,
      (err_ff != ST_OK && !(accept && req.is_last)) |=> (err_ff == $past(err_ff)),
      "latched error changed within a string")

endmodule

### src/arhp_out_queue.sv
// Three-entry result queue that absorbs up to two results per transfer.
`include "assert_macros.svh"
module arhp_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  arhp_pkg::res_pair_type res,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output arhp_pkg::rsp_type      rsp_data
);
   import arhp_pkg::*;

   rsp_type    q_ff [QDEPTH];
   rsp_type    q_in [QDEPTH];
   logic [1:0] cnt_ff, cnt_in, cnt_mid;
   logic       pop;
   logic       push_first, push_second;

   always_comb begin
      pop         = (cnt_ff != 2'd0) && rsp_ready;
      cnt_mid     = cnt_ff - {1'b0, pop};
      room        = (cnt_mid <= 2'd1);
      push_first  = push && res.first_valid;
      push_second = push && res.second_valid;
      for (int i = 0; i < QDEPTH; i++) begin
         if (pop && i < QDEPTH - 1) begin
            q_in[i] = q_ff[(i < QDEPTH - 1) ? i + 1 : i];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (push_first && cnt_mid == i[1:0]) begin
            q_in[i] = res.first;
         end
         if (push_second && (cnt_mid + 2'd1) == i[1:0]) begin
            q_in[i] = res.second;
         end
      end
      cnt_in = cnt_mid + {1'b0, push_first} + {1'b0, push_second};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q_ff[0];

   `ARHP_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= 2'(QDEPTH), "queue overfilled")
   `ARHP_ASSERT_NEVER(a_push_no_room, clock, reset, push && !room, "push without room")
   `ARHP_ASSERT(a_two_push, clock, reset,
      (push_first && push_second && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd2),
      "pair of results not both queued")

endmodule

### src/auth_record_hex_parser_core.sv
// Top level of the hex-encoded authentication record parser.
// Takes one ASCII character per transfer and decodes pairs into bytes, which are
// XORed with the key register and walked through the record header (version,
// MAC count, first MAC, optional second MAC, auth mode, remaining time, user
// length). User name bytes come out as kind 0 results as soon as their second
// character arrives; the character flagged is_last adds a kind 1 summary and
// clears the record state for the next string. Every character is processed in
// the cycle it is accepted and its results are registered into a three-entry
// queue whose head drives the rsp_ payload, so one character per clock is
// sustained while rsp_ready keeps the queue draining. req_ready stays high
// while the queue, after this cycle's drain, has room for two results, so a
// closing character that also yields a user byte always fits in the queue.
// Write csr_ registers only while no string is in flight.
`include "assert_macros.svh"
module auth_record_hex_parser_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  arhp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output arhp_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);
   import arhp_pkg::*;

   logic [7:0]   version_ff, version_in;
   logic [7:0]   key_ff, key_in;
   logic         accept;
   logic         room;
   res_pair_type res;

   // Configuration registers: hold unless written.
   always_comb begin
      version_in = version_ff;
      key_in     = key_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_VERSION: version_in = csr_wdata;
            CSR_KEY:     key_in     = csr_wdata;
            default:     version_in = version_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
         key_ff     <= KEY_RESET;
      end else begin
         version_ff <= version_in;
         key_ff     <= key_in;
      end
   end

   // Accept a transfer whenever the queue can take both possible results.
   assign req_ready = room;
   assign accept    = req_valid && req_ready;

   arhp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req              (req_data),
      .expected_version (version_ff),
      .xor_key          (key_ff),
      .res              (res)
   );

   arhp_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .res       (res),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `ARHP_ASSERT(a_summary_is_last, clock, reset,
      (rsp_valid && rsp_data.kind == KIND_SUMMARY) |-> rsp_data.run_last,
      "summary result without run_last")
   `ARHP_ASSERT(a_user_clean, clock, reset,
      (rsp_valid && rsp_data.kind == KIND_USER) |-> (rsp_data.status == ST_OK
         && rsp_data.user_count == 8'd0),
      "user byte result carries summary fields")
   `ARHP_ASSERT(a_pair_order, clock, reset,
      (res.second_valid && accept) |-> (res.first.kind == KIND_USER
         && res.second.kind == KIND_SUMMARY),
      "result pair out of order")

endmodule
